// ===== rtl/pvt_pkg.sv =====
// ----------------------------------------------------------------------------
// pvt_pkg
// Register indexes and fixed-point limits for the viewport transform.
// ----------------------------------------------------------------------------
package pvt_pkg;

	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_NEAR   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAR    = 3'd5;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	localparam int LANES = 3;

endpackage

// ===== rtl/perspective_viewport_transform.sv =====
// ----------------------------------------------------------------------------
// perspective_viewport_transform
// Stages: input register, one restoring divide stage per quotient bit, clamp,
// products, sums, output. Throughput: one vertex per cycle unless stalled.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears valid bits and loads the viewport and depth registers defaults.
// ----------------------------------------------------------------------------
// Perspective divide of x, y, z by w, then mapping to screen and depth range.
// ----------------------------------------------------------------------------
module perspective_viewport_transform
	import pvt_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int VIEWPORT_BITS = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [31:0]      clip_x,
	input  logic signed [31:0]      clip_y,
	input  logic signed [31:0]      clip_z,
	input  logic signed [31:0]      clip_w,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      screen_x,
	output logic signed [31:0]      screen_y,
	output logic signed [31:0]      screen_depth,
	output logic                    w_invalid,
	output logic                    saturated
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int VB = VIEWPORT_BITS;
	localparam int SW = VB + FRAC_BITS + 36;
	localparam int ZW = 68;

	logic [VB-1:0]      x_min_q, y_min_q, width_q, height_q;
	logic signed [31:0] near_q, far_q;
	logic               en;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= '0;
			y_min_q  <= '0;
			width_q  <= VB'(640);
			height_q <= VB'(480);
			near_q   <= '0;
			far_q    <= 32'(64'sd1 <<< FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_MIN:  x_min_q  <= cfg_data[VB-1:0];
				REG_Y_MIN:  y_min_q  <= cfg_data[VB-1:0];
				REG_WIDTH:  width_q  <= cfg_data[VB-1:0];
				REG_HEIGHT: height_q <= cfg_data[VB-1:0];
				REG_NEAR:   near_q   <= cfg_data;
				REG_FAR:    far_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider pipeline: entry 0 is the input register
	logic [NW-1:0]    dnum_s [NW+1][LANES];
	logic [30:0]      drem_s [NW+1][LANES];
	logic [30:0]      dw_s   [NW+1];
	logic [LANES-1:0] dneg_s [NW+1];
	logic             dinv_s [NW+1];
	logic             dv_s   [NW+1];

	logic signed [31:0] cin [LANES];
	assign cin[0] = clip_x;
	assign cin[1] = clip_y;
	assign cin[2] = clip_z;

	logic [31:0] t  [NW][LANES];
	logic [31:0] df [NW][LANES];
	logic        ge [NW][LANES];

	always_comb begin
		for (int k = 0; k < NW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				t[k][l]  = {drem_s[k][l], dnum_s[k][l][NW-1]};
				ge[k][l] = t[k][l] >= {1'b0, dw_s[k]};
				df[k][l] = t[k][l] - {1'b0, dw_s[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NW; k++)
				dv_s[k] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= in_valid;
			for (int k = 0; k < NW; k++)
				dv_s[k+1] <= dv_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				dneg_s[0][l] <= cin[l][31];
				dnum_s[0][l] <= {(cin[l][31] ? 32'(-cin[l]) : 32'(cin[l])),
					{FRAC_BITS{1'b0}}};
				drem_s[0][l] <= '0;
			end
			dw_s[0]   <= clip_w[30:0];
			dinv_s[0] <= clip_w[31] || (clip_w == 32'sd0);
			for (int k = 0; k < NW; k++) begin
				for (int l = 0; l < LANES; l++) begin
					dnum_s[k+1][l] <= {dnum_s[k][l][NW-2:0], ge[k][l]};
					drem_s[k+1][l] <= ge[k][l] ? df[k][l][30:0] : t[k][l][30:0];
				end
				dw_s[k+1]   <= dw_s[k];
				dneg_s[k+1] <= dneg_s[k];
				dinv_s[k+1] <= dinv_s[k];
			end
		end
	end

	// clamp quotients
	logic signed [31:0] n_s2 [LANES];
	logic               sat_s2, inv_s2, v_s2;
	logic signed [NW:0] qv [LANES];
	logic               qsat [LANES];
	logic signed [31:0] qn [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			qv[l] = dneg_s[NW][l] ? -$signed({1'b0, dnum_s[NW][l]})
				: $signed({1'b0, dnum_s[NW][l]});
			if (qv[l] > (NW+1)'(Q_MAX)) begin
				qn[l] = Q_MAX; qsat[l] = 1'b1;
			end else if (qv[l] < (NW+1)'(Q_MIN)) begin
				qn[l] = Q_MIN; qsat[l] = 1'b1;
			end else begin
				qn[l] = qv[l][31:0]; qsat[l] = 1'b0;
			end
		end
	end

	// products
	logic signed [VB+32:0] px_s3, py_s3;
	logic signed [49:0]    pl_s3;
	logic signed [48:0]    ph_s3;
	logic                  sat_s3, inv_s3, v_s3;
	logic signed [32:0]    dz;

	assign dz = 33'(far_q) - 33'(near_q);

	// sums
	logic signed [SW-1:0] sx_s4, sy_s4;
	logic signed [ZW-1:0] sz_s4;
	logic                 sat_s4, inv_s4, v_s4;
	logic signed [SW-1:0] hx, hy;
	logic [SW-1:0]        offx, offy;
	logic signed [ZW-1:0] pz, hz;
	logic signed [33:0]   mid;

	always_comb begin
		hx   = SW'(px_s3) >>> 1;
		hy   = (-SW'(py_s3)) >>> 1;
		offx = (SW'(x_min_q) << FRAC_BITS) + (SW'(width_q) << (FRAC_BITS - 1));
		offy = (SW'(y_min_q) << FRAC_BITS) + (SW'(height_q) << (FRAC_BITS - 1));
		pz   = (ZW'(ph_s3) <<< 16) + ZW'(pl_s3);
		hz   = pz >>> (FRAC_BITS + 1);
		mid  = (34'(near_q) + 34'(far_q)) >>> 1;
	end

	// final clamp
	logic signed [31:0] cx, cy, cz;
	logic               satx, saty, satz;

	always_comb begin
		if (sx_s4 > SW'(Q_MAX)) begin
			cx = Q_MAX; satx = 1'b1;
		end else if (sx_s4 < SW'(Q_MIN)) begin
			cx = Q_MIN; satx = 1'b1;
		end else begin
			cx = sx_s4[31:0]; satx = 1'b0;
		end
		if (sy_s4 > SW'(Q_MAX)) begin
			cy = Q_MAX; saty = 1'b1;
		end else if (sy_s4 < SW'(Q_MIN)) begin
			cy = Q_MIN; saty = 1'b1;
		end else begin
			cy = sy_s4[31:0]; saty = 1'b0;
		end
		if (sz_s4 > ZW'(Q_MAX)) begin
			cz = Q_MAX; satz = 1'b1;
		end else if (sz_s4 < ZW'(Q_MIN)) begin
			cz = Q_MIN; satz = 1'b1;
		end else begin
			cz = sz_s4[31:0]; satz = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s2      <= dv_s[NW];
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2   <= qn;
			sat_s2 <= qsat[0] || qsat[1] || qsat[2];
			inv_s2 <= dinv_s[NW];

			px_s3  <= $signed({1'b0, width_q}) * n_s2[0];
			py_s3  <= $signed({1'b0, height_q}) * n_s2[1];
			pl_s3  <= dz * $signed({1'b0, n_s2[2][15:0]});
			ph_s3  <= dz * $signed(n_s2[2][31:16]);
			sat_s3 <= sat_s2;
			inv_s3 <= inv_s2;

			sx_s4  <= hx + $signed(offx);
			sy_s4  <= hy + $signed(offy);
			sz_s4  <= hz + ZW'(mid);
			sat_s4 <= sat_s3;
			inv_s4 <= inv_s3;

			screen_x     <= inv_s4 ? 32'sd0 : cx;
			screen_y     <= inv_s4 ? 32'sd0 : cy;
			screen_depth <= inv_s4 ? 32'sd0 : cz;
			w_invalid    <= inv_s4;
			saturated    <= !inv_s4 && (sat_s4 || satx || saty || satz);
		end
	end

endmodule

// ===== bench/perspective_viewport_transform_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_viewport_transform_tb
// Streams clip-space vertices through the perspective divide and viewport
// transform. The bench predicts each screen result, compares it in order and
// walks several viewport and depth-range settings written while idle.
// ----------------------------------------------------------------------------
module perspective_viewport_transform_tb;
	import pvt_pkg::*;

	localparam int FB = 16;
	localparam int VB = 13;
	localparam int LATENCY = 32 + FB + 5;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic               winv;
		logic               sat;
	} screen_t;

	typedef struct {
		logic signed [31:0] x, y, z, w;
		bit                 known;
		screen_t            res;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, in_valid = 0, out_ready = 0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic signed [31:0] clip_x = 0, clip_y = 0, clip_z = 0, clip_w = 0;
	logic cfg_ready, in_ready, out_valid, w_invalid, saturated;
	logic signed [31:0] screen_x, screen_y, screen_depth;

	logic [VB-1:0] vp_xmin, vp_ymin, vp_wid, vp_hgt;
	logic signed [31:0] rng_near, rng_far;

	screen_t pending_screens[$];
	int errors = 0, sent = 0, checked = 0, settings = 0;
	longint cycles = 0;

	perspective_viewport_transform dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("perspective_viewport_transform_tb NOT OK");
			$finish;
		end
	end

	function automatic longint floor_div2n(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clampq(longint v, ref bit sat);
		if (v > QMAX) begin sat = 1; return QMAX; end
		if (v < QMIN) begin sat = 1; return QMIN; end
		return v;
	endfunction

	function automatic screen_t project_vertex(logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cz, logic signed [31:0] cw);
		screen_t r;
		bit sat;
		longint nx, ny, nz, sx, sy, sz, wd, ht, w;
		r = '0;
		sat = 0;
		if (cw <= 0) begin
			r.winv = 1;
			return r;
		end
		w = cw;
		nx = clampq((longint'(cx) * (64'sd1 << FB)) / w, sat);
		ny = clampq((longint'(cy) * (64'sd1 << FB)) / w, sat);
		nz = clampq((longint'(cz) * (64'sd1 << FB)) / w, sat);
		wd = longint'(vp_wid);
		ht = longint'(vp_hgt);
		sx = floor_div2n(wd * nx, 1) + longint'(vp_xmin) * (64'sd1 << FB)
			+ wd * (64'sd1 << (FB - 1));
		sy = floor_div2n(ht * (-ny), 1) + longint'(vp_ymin) * (64'sd1 << FB)
			+ ht * (64'sd1 << (FB - 1));
		sz = floor_div2n((longint'(rng_far) - longint'(rng_near)) * nz, FB + 1)
			+ floor_div2n(longint'(rng_near) + longint'(rng_far), 1);
		r.sx = 32'(clampq(sx, sat));
		r.sy = 32'(clampq(sy, sat));
		r.sz = 32'(clampq(sz, sat));
		r.sat = sat;
		return r;
	endfunction

	task automatic idle_gap(bit quiet);
		int n;
		n = quiet ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
			$urandom_range(0, 2));
		if (n != 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_X_MIN:  vp_xmin = val[VB-1:0];
			REG_Y_MIN:  vp_ymin = val[VB-1:0];
			REG_WIDTH:  vp_wid  = val[VB-1:0];
			REG_HEIGHT: vp_hgt  = val[VB-1:0];
			REG_NEAR:   rng_near = val;
			REG_FAR:    rng_far  = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_screens.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] w, bit quiet);
		idle_gap(quiet);
		in_valid <= 1;
		clip_x <= x;
		clip_y <= y;
		clip_z <= z;
		clip_w <= w;
		do @(posedge clk); while (!in_ready);
		pending_screens.insert(pending_screens.size(), project_vertex(x, y, z, w));
		sent++;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 131072))) - 65536;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_w();
		case ($urandom_range(0, 9))
			0: return -$signed(32'($urandom_range(0, 65536)));
			1: return $urandom;
			2: return $urandom_range(1, 8);
			3: return 32'sh7FFF_FFFF;
			default: return $urandom_range(16384, 1 << 20);
		endcase
	endfunction

	// result side: random stalls, in-order compare
	initial begin
		screen_t got, want;
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			got = '{screen_x, screen_y, screen_depth, w_invalid, saturated};
			if (pending_screens.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, got);
			end else begin
				want = pending_screens.pop_front();
				checked++;
				if (got.sx !== want.sx) begin errors++;
					$display("%0t screen_x exp %h got %h", $time, want.sx, got.sx); end
				if (got.sy !== want.sy) begin errors++;
					$display("%0t screen_y exp %h got %h", $time, want.sy, got.sy); end
				if (got.sz !== want.sz) begin errors++;
					$display("%0t screen_depth exp %h got %h", $time, want.sz, got.sz); end
				if (got.winv !== want.winv) begin errors++;
					$display("%0t w_invalid exp %b got %b", $time, want.winv, got.winv); end
				if (got.sat !== want.sat) begin errors++;
					$display("%0t saturated exp %b got %b", $time, want.sat, got.sat); end
			end
		end
	end

	initial begin
		row_t rows[$];
		screen_t want;
		logic [31:0] cfg_set[6];
		vp_xmin = 0; vp_ymin = 0; vp_wid = 640; vp_hgt = 480;
		rng_near = 0; rng_far = 65536;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		rows = '{
			'{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 1,
				'{32'sd20971520, 32'sd15728640, 32'sd32768, 1'b0, 1'b0}},
			'{32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, 1,
				'{32'sd41943040, 32'sd0, 32'sd65536, 1'b0, 1'b0}},
			'{32'sd123, 32'sd456, 32'sd789, 32'sd0, 1, '{0, 0, 0, 1'b1, 1'b0}},
			'{32'sd5, 32'sd5, 32'sd5, 32'sh8000_0000, 1, '{0, 0, 0, 1'b1, 1'b0}},
			'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 0, '{0, 0, 0, 0, 0}},
			'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 0, '{0, 0, 0, 0, 0}},
			'{-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 0, '{0, 0, 0, 0, 0}},
			'{32'sd32768, -32'sd98304, 32'sd12345, 32'sd131072, 0, '{0, 0, 0, 0, 0}},
			'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
				'{0, 0, 0, 0, 0}},
			'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
				'{0, 0, 0, 0, 0}},
			'{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1, '{0, 0, 0, 1'b1, 1'b0}}
		};
		foreach (rows[i]) begin
			if (rows[i].known) begin
				want = project_vertex(rows[i].x, rows[i].y, rows[i].z, rows[i].w);
				if (want !== rows[i].res) begin
					errors++;
					$display("%0t table row %0d exp %h model %h", $time, i, rows[i].res, want);
				end
			end
			send_vertex(rows[i].x, rows[i].y, rows[i].z, rows[i].w, i < 4);
		end
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: cfg_set = '{0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF};
				1: cfg_set = '{8191, 8191, 8191, 8191, 32'h7FFF_FFFF, 32'h8000_0000};
				2: cfg_set = '{100, 50, 1920, 1080, 0, 32'h0001_0000};
				3: cfg_set = '{32'hFFFF_FFFF, 32'h0000_E000, 1, 8191, 32'hFFFF_0000, 32'h0};
				default: for (int k = 0; k < 6; k++) cfg_set[k] = $urandom;
			endcase
			for (int k = 0; k < 6; k++)
				write_reg(k[CFG_IDX_BITS-1:0], cfg_set[k]);
			write_reg(REG_SPARE_LO, $urandom);
			write_reg(REG_SPARE_HI, $urandom);
			cfg_valid <= 0;
			settings++;
			for (int n = 0; n < 200; n++) begin
				if (n == 100) begin
					in_valid <= 0;
					while (pending_screens.size() != 0) @(posedge clk);
				end
				send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_w(), n > 150);
			end
			drain();
		end

		$display("sent %0d vertices over %0d register settings, %0d results checked",
			sent, settings, checked);
		if (errors == 0)
			$display("perspective_viewport_transform_tb OK");
		else
			$display("perspective_viewport_transform_tb NOT OK");
		$finish;
	end
endmodule
